// File: rtl/core/life_generation_stencil_defines.svh
// Assertion helpers shared by the stencil RTL; both sample on aclk and
// are quiet while aresetn is low.
`ifndef LIFE_GENERATION_STENCIL_DEFINES_SVH
`define LIFE_GENERATION_STENCIL_DEFINES_SVH

// Same-cycle implication.
`define LGS_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("lgs assertion failed");

// Next-cycle implication.
`define LGS_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("lgs assertion failed");

`endif

// File: rtl/core/lgs_pkg.sv
`default_nettype none

package lgs_pkg;

    localparam int CELLS_W = 8;
    localparam int STRIP_W = 3 * CELLS_W;
    localparam int LINE_W  = 2 * CELLS_W;

    localparam int ROW_WORDS_W   = 6;
    localparam int ROWS_IN_USE_W = 9;
    localparam int CFG_DATA_W    = ROWS_IN_USE_W;
    localparam int CFG_IDX_W     = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_ROW_WORDS   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_IN_USE = 1'b1;

    localparam logic [ROW_WORDS_W-1:0]   ROW_WORDS_RST   = 6'd32;
    localparam logic [ROWS_IN_USE_W-1:0] ROWS_IN_USE_RST = 9'd256;
    localparam logic [ROWS_IN_USE_W-1:0] MIN_ROWS        = 9'd3;

    localparam logic [3:0] BIRTH_COUNT = 4'd3;
    localparam logic [3:0] STAY_COUNT  = 4'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRE,
        ST_UPD,
        ST_MAIN,
        ST_TAIL,
        ST_EDGE
    } lgs_state_t;

    // Which parts of the centre word sit on the grid's outer ring.
    typedef struct packed {
        logic row_ring;
        logic left_ring;
        logic right_ring;
    } ring_t;

endpackage

`default_nettype wire

// File: rtl/core/life_generation_stencil.sv
// Results: a word's results are loaded in PRE (row two above, on word 0), MAIN (its
// regular result), TAIL and EDGE (frame end, bottom row) after its beat is taken;
// results lag the grid by one row plus one word. Per input word the block runs:
// accept, one result slot before the line write-back, the write-back, three result
// slots after it, and only then takes another word; slots wait while m_ready is low.
// Reset: synchronous, active low; clears position counters, window, result valid
// and registers to 32 words by 256 rows. Line buffers are not cleared.
`default_nettype none
`include "life_generation_stencil_defines.svh"

module life_generation_stencil
    import lgs_pkg::*;
#(
    parameter int ROW_WORDS_MAX = 32,
    parameter int ROWS_MAX      = 256,
    localparam int WORD_W = (ROW_WORDS_MAX > 1) ? $clog2(ROW_WORDS_MAX) : 1,
    localparam int ROW_W  = (ROWS_MAX > 1) ? $clog2(ROWS_MAX) : 1
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [CELLS_W-1:0]    s_cells,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic      [CELLS_W-1:0]    m_next_cells,
    output logic      [ROW_W-1:0]      m_out_row,
    output logic      [WORD_W-1:0]     m_out_word,
    output logic                       m_last
);

    localparam int EW_W = ROW_WORDS_W + 1;
    localparam int EW_R = (ROW_W + 1 > ROWS_IN_USE_W + 1) ? ROW_W + 1 : ROWS_IN_USE_W + 1;

    // configuration
    logic [ROW_WORDS_W-1:0]   row_words_reg;
    logic [ROWS_IN_USE_W-1:0] rows_in_use_reg;
    logic [EW_W-1:0]          eff_words;
    logic [EW_R-1:0]          eff_rows;
    logic [WORD_W-1:0]        nw_last;
    logic [ROW_W-1:0]         nr_last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_words_reg   <= ROW_WORDS_RST;
            rows_in_use_reg <= ROWS_IN_USE_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_ROW_WORDS:   row_words_reg   <= cfg_wr_data[ROW_WORDS_W-1:0];
                CFG_ROWS_IN_USE: rows_in_use_reg <= cfg_wr_data[ROWS_IN_USE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        priority if (row_words_reg == '0) begin
            eff_words = EW_W'(1);
        end else if (EW_W'(row_words_reg) > EW_W'(ROW_WORDS_MAX)) begin
            eff_words = EW_W'(ROW_WORDS_MAX);
        end else begin
            eff_words = EW_W'(row_words_reg);
        end
        priority if (rows_in_use_reg < MIN_ROWS) begin
            eff_rows = EW_R'(MIN_ROWS);
        end else if (EW_R'(rows_in_use_reg) > EW_R'(ROWS_MAX)) begin
            eff_rows = EW_R'(ROWS_MAX);
        end else begin
            eff_rows = EW_R'(rows_in_use_reg);
        end
    end

    assign nw_last = WORD_W'(eff_words - EW_W'(1));
    assign nr_last = ROW_W'(eff_rows - EW_R'(1));

    // state
    lgs_state_t state_reg, state_next;

    logic [WORD_W-1:0]  in_word_reg;
    logic [ROW_W-1:0]   in_row_reg;
    logic [WORD_W-1:0]  w_reg;
    logic [ROW_W-1:0]   r_reg;
    logic [CELLS_W-1:0] cells_reg;
    logic [STRIP_W-1:0] win_reg [3];

    logic               s_accept;
    logic [WORD_W-1:0]  w_sat;
    logic [ROW_W-1:0]   r_sat;
    logic [LINE_W-1:0]  line_rd;
    logic               upd;

    assign s_accept = s_valid && s_ready;
    assign w_sat = (in_word_reg > nw_last) ? nw_last : in_word_reg;
    assign r_sat = (in_row_reg > nr_last) ? nr_last : in_row_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_word_reg <= '0;
            in_row_reg  <= '0;
        end else if (s_accept) begin
            if (w_sat == nw_last) begin
                in_word_reg <= '0;
                in_row_reg  <= (r_sat == nr_last) ? '0 : r_sat + ROW_W'(1);
            end else begin
                in_word_reg <= w_sat + WORD_W'(1);
                in_row_reg  <= r_sat;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            w_reg     <= w_sat;
            r_reg     <= r_sat;
            cells_reg <= s_cells;
        end
    end

    lgs_line_buf #(
        .DEPTH (ROW_WORDS_MAX),
        .AW    (WORD_W)
    ) u_line_buf (
        .aclk    (aclk),
        .rd_en   (s_accept),
        .rd_addr (w_sat),
        .rd_data (line_rd),
        .wr_en   (upd),
        .wr_addr (w_reg),
        .wr_data ({cells_reg, line_rd[LINE_W-1:CELLS_W]})
    );

    // 3x3 word window: 0 upper, 1 middle, 2 incoming row
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg[0] <= '0;
            win_reg[1] <= '0;
            win_reg[2] <= '0;
        end else if (upd) begin
            win_reg[0] <= {line_rd[CELLS_W-1:0], win_reg[0][STRIP_W-1:CELLS_W]};
            win_reg[1] <= {line_rd[LINE_W-1:CELLS_W], win_reg[1][STRIP_W-1:CELLS_W]};
            win_reg[2] <= {cells_reg, win_reg[2][STRIP_W-1:CELLS_W]};
        end
    end

    // which results this word produces
    logic last_row, last_word;
    logic need_pre, need_main, need_tail;

    assign last_row  = (r_reg == nr_last);
    assign last_word = (w_reg == nw_last);
    assign need_pre  = (w_reg == '0) && (r_reg >= ROW_W'(2));
    assign need_main = (w_reg != '0) && (r_reg != '0);
    assign need_tail = last_row && last_word;

    // shared stencil
    logic               shifted;
    logic [STRIP_W-1:0] ev_top, ev_mid, ev_bot;
    ring_t              ring;
    logic [CELLS_W-1:0] ev_cells;

    assign ev_top = shifted ? (win_reg[0] >> CELLS_W) : win_reg[0];
    assign ev_mid = shifted ? (win_reg[1] >> CELLS_W) : win_reg[1];
    assign ev_bot = shifted ? (win_reg[2] >> CELLS_W) : win_reg[2];

    lgs_evolve u_evolve (
        .top        (ev_top),
        .mid        (ev_mid),
        .bot        (ev_bot),
        .ring       (ring),
        .next_cells (ev_cells)
    );

    // result slot
    logic               m_valid_reg;
    logic [CELLS_W-1:0] next_cells_reg;
    logic [ROW_W-1:0]   out_row_reg;
    logic [WORD_W-1:0]  out_word_reg;
    logic               last_reg;

    logic               slot_free;
    logic               need;
    logic               out_load;
    logic [CELLS_W-1:0] next_cells_sel;
    logic [ROW_W-1:0]   out_row_sel;
    logic [WORD_W-1:0]  out_word_sel;
    logic               last_sel;

    assign slot_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next     = state_reg;
        s_ready        = 1'b0;
        upd            = 1'b0;
        need           = 1'b0;
        shifted        = 1'b0;
        ring           = '0;
        next_cells_sel = ev_cells;
        out_row_sel    = r_reg - ROW_W'(1);
        out_word_sel   = nw_last;
        last_sel       = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    state_next = ST_PRE;
                end
            end
            ST_PRE: begin
                // last word of the row two above, from the old window
                need            = need_pre;
                shifted         = 1'b1;
                ring.row_ring   = (r_reg == ROW_W'(2));
                ring.left_ring  = (nw_last == '0);
                ring.right_ring = 1'b1;
                out_row_sel     = r_reg - ROW_W'(2);
            end
            ST_UPD: begin
                upd        = 1'b1;
                state_next = ST_MAIN;
            end
            ST_MAIN: begin
                need           = need_main;
                ring.row_ring  = (r_reg == ROW_W'(1));
                ring.left_ring = (w_reg == WORD_W'(1));
                out_word_sel   = w_reg - WORD_W'(1);
            end
            ST_TAIL: begin
                need            = need_tail;
                shifted         = 1'b1;
                ring.row_ring   = (r_reg == ROW_W'(1));
                ring.left_ring  = (nw_last == '0);
                ring.right_ring = 1'b1;
            end
            ST_EDGE: begin
                // bottom row passes straight through
                need           = last_row;
                next_cells_sel = cells_reg;
                out_row_sel    = r_reg;
                out_word_sel   = w_reg;
                last_sel       = last_word;
            end
            default: state_next = ST_IDLE;
        endcase

        out_load = need && slot_free;
        if (state_reg == ST_PRE || state_reg == ST_MAIN
                || state_reg == ST_TAIL || state_reg == ST_EDGE) begin
            if (!need || slot_free) begin
                unique case (state_reg)
                    ST_PRE:  state_next = ST_UPD;
                    ST_MAIN: state_next = ST_TAIL;
                    ST_TAIL: state_next = ST_EDGE;
                    default: state_next = ST_IDLE;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            next_cells_reg <= next_cells_sel;
            out_row_reg    <= out_row_sel;
            out_word_reg   <= out_word_sel;
            last_reg       <= last_sel;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_next_cells = next_cells_reg;
    assign m_out_row    = out_row_reg;
    assign m_out_word   = out_word_reg;
    assign m_last       = last_reg;

    `LGS_ASSERT_NEXT(a_accept_starts_item, s_valid && s_ready, state_reg == ST_PRE)
    `LGS_ASSERT_IMP(a_last_on_bottom_row, m_valid && m_last, m_out_row == nr_last)
    `LGS_ASSERT_NEXT(a_load_shows_beat, out_load, m_valid && m_next_cells == $past(next_cells_sel))

endmodule

`default_nettype wire

// File: rtl/core/lgs_line_buf.sv
`default_nettype none

module lgs_line_buf
    import lgs_pkg::*;
#(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  wire logic              aclk,
    input  wire logic              rd_en,
    input  wire logic [AW-1:0]     rd_addr,
    output logic      [LINE_W-1:0] rd_data,
    input  wire logic              wr_en,
    input  wire logic [AW-1:0]     wr_addr,
    input  wire logic [LINE_W-1:0] wr_data
);

    // {middle line, upper line} per word column
    logic [LINE_W-1:0] mem [DEPTH];
    logic [LINE_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: rtl/core/lgs_evolve.sv
`default_nettype none

module lgs_evolve
    import lgs_pkg::*;
(
    input  wire logic [STRIP_W-1:0] top,
    input  wire logic [STRIP_W-1:0] mid,
    input  wire logic [STRIP_W-1:0] bot,
    input  wire ring_t              ring,
    output logic      [CELLS_W-1:0] next_cells
);

    for (genvar gb = 0; gb < CELLS_W; gb++) begin : g_lane
        logic [3:0] cnt;
        logic       alive;
        logic       rule;
        logic       keep;

        assign cnt = {3'b0, top[CELLS_W-1+gb]} + {3'b0, top[CELLS_W+gb]}
                   + {3'b0, top[CELLS_W+1+gb]} + {3'b0, mid[CELLS_W-1+gb]}
                   + {3'b0, mid[CELLS_W+1+gb]} + {3'b0, bot[CELLS_W-1+gb]}
                   + {3'b0, bot[CELLS_W+gb]}   + {3'b0, bot[CELLS_W+1+gb]};
        assign alive = mid[CELLS_W+gb];
        assign rule  = alive ? (cnt == STAY_COUNT || cnt == BIRTH_COUNT)
                             : (cnt == BIRTH_COUNT);
        // ring cells keep their state
        assign keep  = ring.row_ring
                    || (gb == 0 && ring.left_ring)
                    || (gb == CELLS_W - 1 && ring.right_ring);
        assign next_cells[gb] = keep ? alive : rule;
    end

endmodule

`default_nettype wire

// File: bench/tb_life_generation_stencil.sv
`default_nettype none

module tb_life_generation_stencil;
    import lgs_pkg::*;

    localparam int unsigned MAX_WORDS   = 32;
    localparam int unsigned MAX_ROWS    = 256;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned RANDOM_WORDS = 460;

    typedef struct packed {
        logic [7:0] cells;
        logic [7:0] row;
        logic [4:0] word;
        logic       last;
    } next_gen_t;

    logic                  aclk;
    logic                  aresetn     = 1'b0;
    logic                  cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = CFG_ROW_WORDS;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;
    logic                  s_valid     = 1'b0;
    logic                  s_ready;
    logic [CELLS_W-1:0]    s_cells     = '0;
    logic                  m_valid;
    logic                  m_ready     = 1'b0;
    logic [CELLS_W-1:0]    m_next_cells;
    logic [7:0]            m_out_row;
    logic [4:0]            m_out_word;
    logic                  m_last;

    life_generation_stencil uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_cells      (s_cells),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_next_cells (m_next_cells),
        .m_out_row    (m_out_row),
        .m_out_word   (m_out_word),
        .m_last       (m_last)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // grid words waiting for the driver, next-generation words waiting for the DUT
    logic [7:0]  grid_q [$];
    next_gen_t   next_gen_q [$];

    int unsigned words_sent   = 0;
    int unsigned words_taken  = 0;
    int unsigned beats_seen   = 0;
    int unsigned errors       = 0;
    int unsigned settings_run = 0;
    int unsigned cycles       = 0;
    int unsigned s_hold       = 0;
    int unsigned m_hold       = 0;
    logic        s_no_gaps    = 1'b0;
    logic        m_no_stalls  = 1'b0;

    // next-generation model state
    logic [ROW_WORDS_W-1:0]   words_per_row;
    logic [ROWS_IN_USE_W-1:0] rows_per_frame;
    logic [7:0]               line_two_up [MAX_WORDS];
    logic [7:0]               line_one_up [MAX_WORDS];
    logic [23:0]              strip_top, strip_mid, strip_bot;
    int unsigned              next_in_row, next_in_word;

    function automatic int unsigned eff_words();
        if (words_per_row == 0) return 1;
        if (words_per_row > MAX_WORDS) return MAX_WORDS;
        return words_per_row;
    endfunction

    function automatic int unsigned eff_rows();
        if (rows_per_frame < MIN_ROWS) return MIN_ROWS;
        if (rows_per_frame > MAX_ROWS) return MAX_ROWS;
        return rows_per_frame;
    endfunction

    // Centre word of a three-strip window; bit 0 leftmost, neighbors at 7+b..9+b.
    function automatic logic [7:0] evolve_word(input logic [23:0] above, centre_s, below,
                                               input int unsigned q, v, nw, nr);
        logic [7:0]  centre;
        logic [7:0]  res;
        int unsigned count;
        int          b, d;
        centre = centre_s[15:8];
        if (q == 0 || q >= nr - 1) return centre;
        res = '0;
        for (b = 0; b < 8; b++) begin
            if ((v == 0 && b == 0) || (v == nw - 1 && b == 7)) begin
                res[b] = centre[b];
            end else begin
                count = 0;
                for (d = 0; d < 3; d++) begin
                    count += above[7 + b + d];
                    count += below[7 + b + d];
                    if (d != 1) count += centre_s[7 + b + d];
                end
                res[b] = centre[b] ? (count == STAY_COUNT || count == BIRTH_COUNT)
                                   : (count == BIRTH_COUNT);
            end
        end
        return res;
    endfunction

    task automatic push_result(input logic [7:0] cells, input int unsigned row, word,
                               input logic last);
        next_gen_t item;
        item.cells = cells;
        item.row   = row[7:0];
        item.word  = word[4:0];
        item.last  = last;
        next_gen_q = {next_gen_q, item};
    endtask

    task automatic step_generation(input logic [7:0] cells);
        int unsigned nw, nr, w, r;
        logic [7:0]  up, mid;
        nw = eff_words();
        nr = eff_rows();
        // positions left over from a resize saturate
        w = (next_in_word > nw - 1) ? nw - 1 : next_in_word;
        r = (next_in_row > nr - 1) ? nr - 1 : next_in_row;

        if (w == 0 && r >= 2)
            push_result(evolve_word(strip_top >> 8, strip_mid >> 8, strip_bot >> 8,
                                    r - 2, nw - 1, nw, nr), r - 2, nw - 1, 1'b0);

        up  = line_two_up[w];
        mid = line_one_up[w];
        line_two_up[w] = mid;
        line_one_up[w] = cells;
        strip_top = {up, strip_top[23:8]};
        strip_mid = {mid, strip_mid[23:8]};
        strip_bot = {cells, strip_bot[23:8]};

        if (w >= 1 && r >= 1)
            push_result(evolve_word(strip_top, strip_mid, strip_bot, r - 1, w - 1, nw, nr),
                        r - 1, w - 1, 1'b0);

        // bottom row is all ring: passes straight through, frame end drains the row above
        if (r == nr - 1) begin
            if (w == nw - 1)
                push_result(evolve_word(strip_top >> 8, strip_mid >> 8, strip_bot >> 8,
                                        r - 1, nw - 1, nw, nr), r - 1, nw - 1, 1'b0);
            push_result(cells, r, w, w == nw - 1);
        end

        if (w == nw - 1) begin
            next_in_word = 0;
            next_in_row  = (r == nr - 1) ? 0 : r + 1;
        end else begin
            next_in_word = w + 1;
            next_in_row  = r;
        end
    endtask

    // input driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_hold  <= 0;
        end else if (!s_valid || s_ready) begin
            if (s_hold != 0) begin
                s_valid <= 1'b0;
                s_hold  <= s_hold - 1;
            end else if (grid_q.size() != 0) begin
                s_valid <= 1'b1;
                s_cells <= grid_q.pop_front();
                s_hold  <= s_no_gaps ? 0 : $urandom_range(0, 8);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result-side backpressure
    always @(posedge aclk) begin : receiver
        int unsigned stall;
        if (!aresetn) begin
            m_ready <= 1'b0;
            m_hold  <= 0;
        end else if (m_valid && m_ready) begin
            stall = m_no_stalls ? 0 : $urandom_range(0, 8);
            m_hold  <= stall;
            m_ready <= (stall == 0);
        end else if (m_hold != 0) begin
            m_hold  <= m_hold - 1;
            m_ready <= (m_hold == 1);
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin : generation_check
        next_gen_t got, want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                step_generation(s_cells);
                words_taken++;
            end
            if (m_valid && m_ready) begin
                beats_seen++;
                got = {m_next_cells, m_out_row, m_out_word, m_last};
                if (next_gen_q.size() == 0) begin
                    errors++;
                    $display("%0t: expected no beat, got %h r%0d w%0d l%b",
                             $time, got.cells, got.row, got.word, got.last);
                end else begin
                    want = next_gen_q.pop_front();
                    if (got !== want) begin
                        errors++;
                        $display("%0t: expected %h r%0d w%0d l%b, got %h r%0d w%0d l%b",
                                 $time, want.cells, want.row, want.word, want.last,
                                 got.cells, got.row, got.word, got.last);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("%0t: timed out with %0d beats still expected", $time, next_gen_q.size());
            $display("life_generation_stencil: mismatch");
            $finish;
        end
    end

    task automatic send_word(input logic [7:0] cells);
        grid_q = {grid_q, cells};
        words_sent++;
    endtask

    function automatic logic [7:0] random_cells(input int unsigned density);
        case (density)
            0:       return 8'($urandom & $urandom);
            1:       return 8'($urandom);
            2:       return 8'($urandom | $urandom);
            default: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
        endcase
    endfunction

    // all words taken and answered, then a pause for a row-0 word still in flight
    task automatic wait_drained();
        while (words_taken != words_sent || next_gen_q.size() != 0) @(negedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == CFG_ROW_WORDS) words_per_row = data[ROW_WORDS_W-1:0];
        else rows_per_frame = data;
    endtask

    task automatic set_frame(input int unsigned words, rows);
        logic [CFG_DATA_W-1:0] data;
        wait_drained();
        // upper bits above the 6-bit register are don't-care
        data = {3'($urandom_range(0, 7)), words[ROW_WORDS_W-1:0]};
        write_register(CFG_ROW_WORDS, data);
        write_register(CFG_ROWS_IN_USE, rows[CFG_DATA_W-1:0]);
        s_no_gaps   = ($urandom_range(0, 3) == 0);
        m_no_stalls = ($urandom_range(0, 3) == 0);
        settings_run++;
    endtask

    task automatic random_frame(input int unsigned words, rows);
        int unsigned n, density;
        set_frame(words, rows);
        density = $urandom_range(0, 3);
        for (n = 0; n < eff_words() * eff_rows(); n++) send_word(random_cells(density));
    endtask

    initial begin : stimulus
        int unsigned i, base;
        words_per_row  = ROW_WORDS_RST;
        rows_per_frame = ROWS_IN_USE_RST;
        for (i = 0; i < MAX_WORDS; i++) begin
            line_two_up[i] = '0;
            line_one_up[i] = '0;
        end
        strip_top    = '0;
        strip_mid    = '0;
        strip_bot    = '0;
        next_in_row  = 0;
        next_in_word = 0;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // both sizes clamped up to the minimum 1 x 3 grid
        set_frame(0, 0);
        send_word(8'hFF);
        send_word(8'h7E);
        send_word(8'h00);

        // blinker across the word seam, 2 x 4
        set_frame(2, 4);
        send_word(8'h00); send_word(8'h00);
        send_word(8'h80); send_word(8'h03);
        send_word(8'hFF); send_word(8'h01);
        send_word(8'h55); send_word(8'hAA);

        set_frame(3, 2);
        send_word(8'h00); send_word(8'hFF); send_word(8'h00);
        send_word(8'hFF); send_word(8'hFF); send_word(8'hFF);
        send_word(8'h01); send_word(8'h80); send_word(8'h00);

        base = words_sent;
        // full-width frame (63 clamps to 32) writes every line buffer entry
        random_frame(63, 3);

        // resize in mid-frame: row 4 word 3 saturates to row 2 word 1
        set_frame(8, 6);
        repeat (35) send_word(random_cells(1));
        wait_drained();
        write_register(CFG_ROW_WORDS, CFG_DATA_W'(2));
        write_register(CFG_ROWS_IN_USE, CFG_DATA_W'(3));
        settings_run++;
        do begin
            send_word(random_cells(2));
            wait_drained();
        end while (next_in_row != 0 || next_in_word != 0);

        // tallest frame, rows clamped from 511
        random_frame(1, 511);

        while (words_sent - base < RANDOM_WORDS)
            random_frame($urandom_range(0, 5), $urandom_range(0, 8));

        wait_drained();
        $display("covered %0d grid words and %0d result beats over %0d size settings,",
                 words_sent, beats_seen, settings_run);
        $display("including clamped sizes, a 256-row frame and a mid-frame resize");
        if (errors == 0) $display("life_generation_stencil: match");
        else $display("life_generation_stencil: mismatch");
        $finish;
    end

endmodule

`default_nettype wire
